// ===== rtl/s2dec_pkg.sv =====
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none

package s2dec_pkg;

  // Width of the signed value that is converted; only this many low input bits count.
  localparam int VALUE_BITS = 32;
  // Width of the input field on the stream port.
  localparam int INPUT_BITS = 32;
  // Width of the zero-extended copy of the input from which the value is taken.
  localparam int WIDE_BITS = 64;
  // Decimal digits needed for the largest magnitude: floor(VALUE_BITS * log10(2)) + 1.
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS = 8;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE = 8'd57;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

  // Shift-and-add-3 correction for a radix of ten.
  localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;
  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands broadcast to every digit cell of the row.
  typedef struct packed {
    logic clear;
    logic conv;
    logic emit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/s2dec_cell.sv =====
// One decimal digit cell of the shift-and-add-3 row, which also shifts digits out.
`default_nettype none

module s2dec_cell (
  input  wire                                   clk,
  input  s2dec_pkg::cell_ctrl_t                 ctrl,
  input  wire                                   shift_in,
  input  wire  [s2dec_pkg::DIGIT_BITS-1:0]      digit_in,
  output logic                                  carry,
  output logic [s2dec_pkg::DIGIT_BITS-1:0]      digit
);
  import s2dec_pkg::*;

  logic [DIGIT_BITS-1:0] adj;

  // The correction depends on this cell's own digit only, so carries do not ripple.
  assign adj = (digit >= DABBLE_LIMIT) ? digit + DABBLE_ADD : digit;
  assign carry = adj[DIGIT_BITS-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {adj[DIGIT_BITS-2:0], shift_in};
    end else if (ctrl.emit) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed integer in, decimal ASCII characters out, one per transfer.
`default_nettype none

// Takes one signed value per input transfer and sends its decimal text, one ASCII
// character per output transfer: a leading '-' for negative values, then the digits
// of the magnitude, most significant first, without leading zeros; zero gives a single
// '0'. The final character of each number has tlast set. The magnitude is converted
// by a row of digit cells with shift-and-add-3, one value bit per cycle, and the same
// row then shifts the digits out of its top cell; a stalled output holds the block. The
// next value is taken as soon as the last character sits in the output register.
module signed_int_to_decimal_ascii_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [s2dec_pkg::INPUT_BITS-1:0]   s_tdata,  // [31:0] value
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [s2dec_pkg::CHAR_BITS-1:0]    m_tdata,  // [7:0] character
  output logic                               m_tlast   // last_char
);
  import s2dec_pkg::*;

  state_t                state, state_next;
  cell_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [DIG_CNT_W-1:0]  dig_cnt;
  logic                  started;

  logic [WIDE_BITS-1:0]  in_wide;
  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [CHAR_BITS-1:0]  out_char;
  logic                  out_last;
  logic                  show;

  logic                  chain [NUM_DIGITS:0];
  logic [DIGIT_BITS-1:0] dig   [NUM_DIGITS:0];
  logic [DIGIT_BITS-1:0] top;

  assign in_wide = WIDE_BITS'(s_tdata);
  assign raw = in_wide[VALUE_BITS-1:0];
  assign raw_neg = raw[VALUE_BITS-1];
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign top = dig[NUM_DIGITS];
  assign show = started || (top != '0) || (dig_cnt == DIG_CNT_W'(1));

  // Row of digit cells: the value enters bit by bit at the bottom, digits leave at the top.
  assign chain[0] = mag[VALUE_BITS-1];
  assign dig[0] = '0;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    s2dec_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .shift_in (chain[i]),
      .digit_in (dig[i]),
      .carry    (chain[i+1]),
      .digit    (dig[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    s_tready = 1'b0;
    out_load = 1'b0;
    out_char = ASCII_MINUS;
    out_last = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_char = ASCII_ZERO + CHAR_BITS'(top);
        out_last = (dig_cnt == DIG_CNT_W'(1));
        if (!show) begin
          // Leading zero: drop it without a transfer.
          ctrl.emit = 1'b1;
        end else if (out_free) begin
          ctrl.emit = 1'b1;
          out_load = 1'b1;
          if (out_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= raw_neg;
      mag <= raw_neg ? ('0 - raw) : raw;
      bit_cnt <= BIT_CNT_W'(VALUE_BITS);
      dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
    end else begin
      if (ctrl.conv) begin
        mag <= mag << 1;
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (ctrl.emit) begin
        dig_cnt <= dig_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (accept) begin
      started <= 1'b0;
    end else if (ctrl.emit && show) begin
      started <= 1'b1;
    end
  end

  // Output register decouples the row from a stalled consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_char;
      m_tlast <= out_last;
    end
  end

  // The top cell must never carry out: the row is wide enough for every magnitude.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !chain[NUM_DIGITS])
    else $error("digit row overflowed during conversion");

  // Digits leaving the row are always decimal.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top <= DIGIT_MAX))
    else $error("non-decimal digit in the top cell");

  // The final character of a number is always a digit, never the sign.
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE))
    else $error("end mark on a character that is not a digit");

  // An accepted value always starts a conversion pass.
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV))
    else $error("accepted value did not start conversion");

endmodule

`default_nettype wire

// ===== dv/signed_int_to_decimal_ascii_checker.sv =====
// Checker for the decimal text converter: predicts each character and compares the output stream.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  input  wire                                s_tready,
  input  wire  [s2dec_pkg::INPUT_BITS-1:0]   s_tdata,   // [31:0] value
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  input  wire  [s2dec_pkg::CHAR_BITS-1:0]    m_tdata,   // [7:0] character
  input  wire                                m_tlast,   // last_char
  output logic [31:0]                        fail_count,
  output logic [31:0]                        pending,
  output logic [31:0]                        numbers_seen,
  output logic [31:0]                        chars_seen
);
  import s2dec_pkg::*;

  localparam int DECIMAL_RADIX = 10;
  localparam int MAX_TEXT_DIGITS = 20;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    numbers_seen = 0;
    chars_seen   = 0;
  end

  // Appends the sign and the digits of one value, most significant digit first.
  task automatic queue_decimal_text(input logic [INPUT_BITS-1:0] word);
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  negative;
    logic [3:0]            digit_buf [MAX_TEXT_DIGITS];
    int                    n_digits;
    text_char_t            entry;
    raw       = word[VALUE_BITS-1:0];
    negative  = raw[VALUE_BITS-1];
    // Unsigned negation, so the most negative value keeps its true magnitude.
    magnitude = negative ? (~raw + 1'b1) : raw;
    n_digits  = 0;
    do begin
      digit_buf[n_digits] = 4'(magnitude % DECIMAL_RADIX);
      magnitude           = VALUE_BITS'(magnitude / DECIMAL_RADIX);
      n_digits++;
    end while (magnitude != 0 && n_digits < MAX_TEXT_DIGITS);
    if (negative) begin
      entry.ch   = ASCII_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      entry.ch   = ASCII_ZERO + CHAR_BITS'(digit_buf[i]);
      entry.last = (i == 0);
      expected_text.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_decimal_text(s_tdata);
        numbers_seen <= numbers_seen + 1;
      end
      if (m_tvalid && m_tready) begin
        chars_seen <= chars_seen + 1;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %0d (last %0b)",
                   $time, m_tdata, m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (m_tdata !== want.ch || m_tlast !== want.last) begin
            $display("%0t: character mismatch, expected %0d (last %0b), got %0d (last %0b)",
                     $time, want.ch, want.last, m_tdata, m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= 32'(expected_text.size());
  end

endmodule

// ===== dv/signed_int_to_decimal_ascii_core_tb.sv =====
// Testbench top: drives values into the converter, paces the output side and reports the verdict.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;
  import s2dec_pkg::*;

  localparam int N_CORNERS = 20;
  localparam int N_RANDOM = 80;
  localparam int MAX_GAP = 18;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [INPUT_BITS-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CHAR_BITS-1:0]  m_tdata;
  logic                  m_tlast;

  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] numbers_seen;
  logic [31:0] chars_seen;
  int          cycle_count = 0;

  // Zero, single and ten-digit magnitudes, both signs and both extremes of the range.
  logic [31:0] corner_values [N_CORNERS] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009, 32'h0000_000A,
    32'hFFFF_FFF6, 32'hFFFF_FFF7, 32'h0000_0063, 32'h0000_0064, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h3B9A_CA00, 32'hC465_3600, 32'h3B9A_C9FF,
    32'h4996_02D2, 32'hB669_FD2E, 32'h5555_5555, 32'hAAAA_AAAA, 32'h000F_4240
  };

  signed_int_to_decimal_ascii_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  signed_int_to_decimal_ascii_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .numbers_seen (numbers_seen),
    .chars_seen   (chars_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Draws a value from a mix of magnitude classes so that every digit count turns up often.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    logic [31:0] pow10;
    int          sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: v = $urandom;
      3: v = $urandom_range(0, 20);
      4: begin
        pow10 = 1;
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
        v = pow10 - 1 + $urandom_range(0, 2);
      end
      5: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      6: v = $urandom_range(1000000000, 2147483647);
      default: v = $urandom_range(0, 99999);
    endcase
    if (sel != 0 && sel != 1 && sel != 2 && sel != 5 && $urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v, input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // Output side: a random hold-off before each character, with stall-free stretches.
  initial begin
    int gap;
    int n_taken;
    n_taken = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = ((n_taken / 40) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_taken++;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_CORNERS; i++)
      send_value(corner_values[i], (i % 7) != 3);
    for (int i = 0; i < N_RANDOM; i++)
      send_value(random_value(), (i / 12) % 3 != 1);
    s_tvalid <= 1'b0;

    // Let the checker queue the final value before pending is polled.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d characters, with zero, both extremes,",
             numbers_seen, chars_seen);
    $display("ten-digit magnitudes and random stalls on both sides.");
    if (pending != 0)
      $display("%0t: %0d expected characters never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
